### design/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and codes for the serial frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Parser states (code 7 is unused and treated as waiting for header one)
  typedef enum logic [2:0] {
    ST_HDR1    = 3'd0,
    ST_HDR2    = 3'd1,
    ST_CMD     = 3'd2,
    ST_LEN_HI  = 3'd3,
    ST_LEN_LO  = 3'd4,
    ST_PAYLOAD = 3'd5,
    ST_CHECK   = 3'd6
  } sfp_state_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_SUM  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } sfp_kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;

  // Configuration seen by the parser
  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] max_payload;
  } sfp_cfg_t;

  // One result
  typedef struct packed {
    sfp_kind_t   kind;
    logic [7:0]  command;
    logic [7:0]  data;
    logic [15:0] length;
  } sfp_result_t;

endpackage

### design/sfp_regs.sv
// ----------------------------------------------------------------------------
// sfp_regs
// Configuration register file: header bytes and payload length limit.
// ----------------------------------------------------------------------------
module sfp_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [15:0]       wr_data,
  output sfp_pkg::sfp_cfg_t cfg
);
  import sfp_pkg::*;

  sfp_cfg_t cfg_r;

  // Register writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= HEADER_FIRST_RST;
      cfg_r.header_second <= HEADER_SECOND_RST;
      cfg_r.max_payload   <= MAX_PAYLOAD_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEADER_FIRST:  cfg_r.header_first  <= wr_data[7:0];
        REG_HEADER_SECOND: cfg_r.header_second <= wr_data[7:0];
        REG_MAX_PAYLOAD:   cfg_r.max_payload   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/sfp_parse.sv
// ----------------------------------------------------------------------------
// sfp_parse
// Frame parser: state registers plus one-byte step logic.
// ----------------------------------------------------------------------------
module sfp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfp_pkg::sfp_cfg_t    cfg,
  input  logic                 byte_vld,
  input  logic [7:0]           rx_byte,
  output logic                 res_vld,
  output sfp_pkg::sfp_result_t res,
  output sfp_pkg::sfp_state_t  state
);
  import sfp_pkg::*;

  sfp_state_t  state_r, state_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  assign len_full = {len_r[15:8], rx_byte};
  assign cnt_inc  = cnt_r + 16'd1;

  // Next state and result for the byte on the input
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    res_vld     = 1'b0;
    res.kind    = KIND_PAYLOAD;
    res.command = cmd_r;
    res.data    = 8'd0;
    res.length  = len_r;
    case (state_r)
      ST_HDR2: begin
        // second header wins when both headers are equal
        if (rx_byte == cfg.header_second) begin
          state_nxt = ST_CMD;
        end else if (rx_byte != cfg.header_first) begin
          state_nxt = ST_HDR1;
        end
      end
      ST_CMD: begin
        cmd_nxt   = rx_byte;
        xor_nxt   = rx_byte;
        state_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_nxt   = {rx_byte, 8'd0};
        xor_nxt   = xor_r ^ rx_byte;
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        if (len_full > cfg.max_payload) begin
          res_vld    = 1'b1;
          res.kind   = KIND_TOO_LONG;
          res.length = len_full;
          state_nxt  = ST_HDR1;
          cmd_nxt    = 8'd0;
          len_nxt    = 16'd0;
          cnt_nxt    = 16'd0;
          xor_nxt    = 8'd0;
        end else begin
          len_nxt   = len_full;
          xor_nxt   = xor_r ^ rx_byte;
          cnt_nxt   = 16'd0;
          state_nxt = (len_full == 16'd0) ? ST_CHECK : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        // pass the byte through, still tentative
        xor_nxt  = xor_r ^ rx_byte;
        cnt_nxt  = cnt_inc;
        if (cnt_inc >= len_r) begin
          state_nxt = ST_CHECK;
        end
        res_vld  = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.data = rx_byte;
      end
      ST_CHECK: begin
        res_vld   = 1'b1;
        res.kind  = (rx_byte == xor_r) ? KIND_GOOD : KIND_BAD_SUM;
        state_nxt = ST_HDR1;
        cmd_nxt   = 8'd0;
        len_nxt   = 16'd0;
        cnt_nxt   = 16'd0;
        xor_nxt   = 8'd0;
      end
      default: begin
        // waiting for header one (also the unused code)
        state_nxt = (rx_byte == cfg.header_first) ? ST_HDR2 : ST_HDR1;
      end
    endcase
  end

  // State registers advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HDR1;
      cmd_r   <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
      xor_r   <= 8'd0;
    end else if (byte_vld) begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

  assign state = state_r;

endmodule

### design/sfp_outq.sv
// ----------------------------------------------------------------------------
// sfp_outq
// Two-entry result queue: output register plus skid slot.
// ----------------------------------------------------------------------------
module sfp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfp_pkg::sfp_result_t push_res,
  output logic                 full,
  output logic                 out_vld,
  input  logic                 out_stall,
  output sfp_pkg::sfp_result_t out_res
);
  import sfp_pkg::*;

  logic        v0_r, v0_nxt;
  logic        v1_r, v1_nxt;
  sfp_result_t d0_r, d0_nxt;
  sfp_result_t d1_r, d1_nxt;
  logic        pop;

  assign pop = v0_r & ~out_stall;

  // Slot 0 drives the port; slot 1 catches a request while slot 0 is stalled
  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      if (v1_r) begin
        d0_nxt = d1_r;
        v1_nxt = push;
        d1_nxt = push_res;
      end else begin
        v0_nxt = push;
        d0_nxt = push_res;
      end
    end else if (push) begin
      if (!v0_r) begin
        v0_nxt = 1'b1;
        d0_nxt = push_res;
      end else begin
        v1_nxt = 1'b1;
        d1_nxt = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign full    = v1_r;
  assign out_vld = v0_r;
  assign out_res = d0_r;

endmodule

### design/serial_frame_parser_xor.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_xor
// Byte-serial frame finder: header pair, command, 16-bit length, payload
// passed through, XOR checksum check.
// ----------------------------------------------------------------------------
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_stall, in_rx_byte        | request in
//   out     | out_valid, out_stall, out_result_kind,| request out
//           | out_command, out_data,                |
//           | out_payload_length                    |
//   cfg     | cfg_valid, cfg_ready, cfg_index,      | write in
//           | cfg_data                              |
//
// One byte per cycle while in_stall is low; the parser step is combinational logic
// after the state registers, and its result lands in a two-entry output queue.
// A result is visible in the cycle after its byte is accepted if the queue is empty.
// in_stall is high while the skid entry is held; it clears in the cycle after
// out_stall drops. Reset (synchronous, rst_n low) clears the parser and loads
// register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module serial_frame_parser_xor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_command,
  output logic [7:0]  out_data,
  output logic [15:0] out_payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sfp_pkg::*;

  sfp_cfg_t    cfg;
  sfp_result_t step_res;
  sfp_result_t q_res;
  sfp_state_t  state;
  logic        step_vld;
  logic        accept;
  logic        q_full;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & ~q_full;
  assign in_stall  = q_full;

  // Configuration registers
  sfp_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Parser
  sfp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .byte_vld (accept),
    .rx_byte  (in_rx_byte),
    .res_vld  (step_vld),
    .res      (step_res),
    .state    (state)
  );

  // Output queue
  sfp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept & step_vld),
    .push_res  (step_res),
    .full      (q_full),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_res   (q_res)
  );

  assign out_result_kind    = q_res.kind;
  assign out_command        = q_res.command;
  assign out_data           = q_res.data;
  assign out_payload_length = q_res.length;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> out_valid)
    else $error("skid entry held without output entry");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != KIND_PAYLOAD)) |-> (out_data == 8'd0))
    else $error("data nonzero on a frame result");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (state == ST_CHECK)) |=> (state == ST_HDR1))
    else $error("parser did not return to header search after checksum");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (state == ST_PAYLOAD)) |=> out_valid)
    else $error("payload byte produced no result");

endmodule

### tb/serial_frame_parser_xor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_parser_xor_test
// Self-checking bench for the serial frame parser. Byte requests go in under
// random gaps and output stalls. A scoreboard tracks the parser state and
// registers, predicts each payload, good, bad-sum and too-long result, and
// compares it with what comes out. Directed frames run first, then phases of
// random frames under different header and length-limit settings.
// ----------------------------------------------------------------------------
module serial_frame_parser_xor_test;
  import sfp_pkg::*;

  // Tracks the frame parser and holds the results still owed by the block
  class frame_scoreboard;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    logic [15:0] max_len;
    sfp_state_t  parse_st;
    logic [7:0]  cmd;
    logic [15:0] decl_len;
    logic [15:0] rcv_count;
    logic [7:0]  xsum;
    sfp_result_t expected_results[$];
    int          errors;

    function new();
      hdr_first  = HEADER_FIRST_RST;
      hdr_second = HEADER_SECOND_RST;
      max_len    = MAX_PAYLOAD_RST;
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      parse_st  = ST_HDR1;
      cmd       = 8'h00;
      decl_len  = 16'h0000;
      rcv_count = 16'h0000;
      xsum      = 8'h00;
    endfunction

    // Register write; unknown indexes are dropped
    function void load_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_HEADER_FIRST:  hdr_first = value[7:0];
        REG_HEADER_SECOND: hdr_second = value[7:0];
        REG_MAX_PAYLOAD:   max_len = value;
        default: ;
      endcase
    endfunction

    function void add_expected(sfp_kind_t kind, logic [7:0] data);
      sfp_result_t r;
      r.kind    = kind;
      r.command = cmd;
      r.data    = data;
      r.length  = decl_len;
      expected_results.push_back(r);
    endfunction

    // One accepted byte request: advance the parser, queue any result
    function void note_byte(logic [7:0] b);
      case (parse_st)
        ST_HDR2: begin
          // second header is tested first, so equal headers move on
          if (b == hdr_second) parse_st = ST_CMD;
          else if (b != hdr_first) parse_st = ST_HDR1;
        end
        ST_CMD: begin
          cmd      = b;
          xsum     = b;
          parse_st = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          decl_len = {b, 8'h00};
          xsum     = xsum ^ b;
          parse_st = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          decl_len[7:0] = b;
          xsum          = xsum ^ b;
          if (decl_len > max_len) begin
            add_expected(KIND_TOO_LONG, 8'h00);
            clear_frame();
          end else begin
            rcv_count = 16'h0000;
            parse_st  = (decl_len == 16'h0000) ? ST_CHECK : ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          xsum      = xsum ^ b;
          rcv_count = rcv_count + 16'd1;
          if (rcv_count >= decl_len) parse_st = ST_CHECK;
          add_expected(KIND_PAYLOAD, b);
        end
        ST_CHECK: begin
          add_expected((b == xsum) ? KIND_GOOD : KIND_BAD_SUM, 8'h00);
          clear_frame();
        end
        default: begin
          // waiting for header one; the unused code lands here too
          parse_st = (b == hdr_first) ? ST_HDR2 : ST_HDR1;
        end
      endcase
    endfunction

    function void report(string msg);
      if (errors < 10) $display("%0t ns: %s", $time, msg);
      errors++;
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(sfp_result_t got);
      sfp_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d cmd %02h data %02h len %0d",
                         got.kind, got.command, got.data, got.length));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.command !== want.command ||
          got.data !== want.data || got.length !== want.length)
        report({$sformatf("result mismatch: exp kind %0d cmd %02h data %02h len %0d, ",
                          want.kind, want.command, want.data, want.length),
                $sformatf("got kind %0d cmd %02h data %02h len %0d",
                          got.kind, got.command, got.data, got.length)});
    endfunction
  endclass

  localparam logic [1:0] REG_UNUSED    = 2'd3;
  localparam int         HOLD_CYCLES   = 80;
  localparam int         PHASE_BYTES   = 140;
  localparam int         NUM_PHASES    = 8;
  localparam int         SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_command;
  logic [7:0]  out_data;
  logic [15:0] out_payload_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  frame_scoreboard sb = new();
  bit              fast = 1'b0;       // no gaps on either side
  bit              long_hold = 1'b0;  // receiver holds off for a long stretch
  int unsigned     bytes_sent = 0;

  serial_frame_parser_xor i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_command        (out_command),
    .out_data           (out_data),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result receiver: random stall before each request, plus one long hold
  initial begin : result_receiver
    int unsigned n;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        n = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        n = fast ? 0 : $urandom_range(0, 6);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    sfp_result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.kind    = sfp_kind_t'(out_result_kind);
      seen.command = out_command;
      seen.data    = out_data;
      seen.length  = out_payload_length;
      sb.check_result(seen);
    end
  end

  // One byte request; valid stays high if the next one follows at once
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = fast ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.load_register(idx, value);
  endtask

  // Load all registers; junk in the unused upper bits of the byte registers
  task automatic configure(input logic [7:0] hf, input logic [7:0] hs,
                           input logic [15:0] limit, input bit stray);
    write_register(REG_HEADER_FIRST, {8'($urandom), hf});
    write_register(REG_HEADER_SECOND, {8'($urandom), hs});
    write_register(REG_MAX_PAYLOAD, limit);
    if (stray) write_register(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pauses until every owed result has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Build a frame under the current headers; cut != 0 sends only a prefix
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input bit bad_sum, input int unsigned reps,
                            input int unsigned cut);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned n;
    for (int i = 0; i <= reps; i++) frame_bytes.push_back(sb.hdr_first);
    frame_bytes.push_back(sb.hdr_second);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    sum = cmd ^ len[15:8] ^ len[7:0];
    if (len <= sb.max_len) begin
      for (int i = 0; i < len; i++) begin
        b   = 8'($urandom);
        sum = sum ^ b;
        frame_bytes.push_back(b);
      end
      frame_bytes.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
    n = (cut != 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
  endtask

  // Feed filler bytes until the parser is back to hunting for a header
  task automatic resync();
    logic [7:0] b;
    while (sb.parse_st != ST_HDR1) begin
      case (sb.parse_st)
        ST_HDR2: begin
          do b = 8'($urandom); while (b == sb.hdr_first || b == sb.hdr_second);
        end
        ST_LEN_HI: b = 8'h00;   // keep the length short
        default:   b = 8'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  // Mostly good frames, some too-long, bad-sum, noise and cut-off frames
  task automatic random_request();
    int unsigned pick;
    int unsigned len_cap;
    int unsigned reps;
    logic [15:0] len;
    logic [7:0]  b;
    pick    = $urandom_range(0, 99);
    len_cap = (sb.max_len < 12) ? sb.max_len : 12;
    if (pick < 70 || (pick < 82 && sb.max_len == 16'hFFFF)) begin
      len = 16'($urandom_range(0, len_cap));
      if ($urandom_range(0, 9) == 0 && sb.max_len <= 64) len = sb.max_len;
      reps = 0;
      if (sb.hdr_first != sb.hdr_second && $urandom_range(0, 5) == 0)
        reps = $urandom_range(1, 2);
      send_frame(8'($urandom), len, $urandom_range(0, 4) == 0, reps, 0);
    end else if (pick < 82) begin
      len = 16'($urandom_range(sb.max_len + 1, 65535));
      send_frame(8'($urandom), len, 1'b0, 0, 0);
    end else if (pick < 92) begin
      // junk between frames, never a header start
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom); while (b == sb.hdr_first);
        send_byte(b);
      end
    end else begin
      len = 16'($urandom_range(0, len_cap));
      send_frame(8'($urandom), len, 1'b0, 0, $urandom_range(1, 5 + len));
      resync();
    end
  endtask

  // Main sequence
  initial begin : stimulus
    int unsigned phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: junk, zero length, repeated header, too long, bad checksum
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 16'd0, 1'b0, 0, 0);
    send_frame(8'hFF, 16'd2, 1'b0, 1, 0);
    send_frame(8'h5A, 16'hFFFF, 1'b0, 0, 0);
    send_frame(8'h00, 16'd0, 1'b1, 0, 0);
    wait_for_results();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      fast = (phase == 1 || phase == 4);
      case (phase)
        0: configure(8'h00, 8'hFF, 16'd0, 1'b0);
        1: configure(8'hFF, 8'h00, 16'hFFFF, 1'b0);
        2: begin
          // equal headers
          phase_start = $urandom_range(0, 255);
          configure(8'(phase_start), 8'(phase_start), 16'd40, 1'b0);
        end
        3: configure(8'h55, 8'hAA, 16'hFFFE, 1'b0);
        4: configure(8'($urandom), 8'($urandom), 16'd12, 1'b0);
        5: configure(8'($urandom), 8'($urandom), 16'($urandom_range(0, 64)), 1'b1);
        default: configure(8'($urandom), 8'($urandom), 16'($urandom_range(0, 300)), 1'b0);
      endcase

      if (phase == 3) begin
        // receiver holds off while the sender keeps pushing payload
        long_hold = 1'b1;
        fast      = 1'b1;
        send_frame(8'($urandom), 16'd12, 1'b0, 0, 0);
        fast      = 1'b0;
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) random_request();
      resync();
      wait_for_results();
    end

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
design/sfp_pkg.sv
design/sfp_regs.sv
design/sfp_parse.sv
design/sfp_outq.sv
design/serial_frame_parser_xor.sv
tb/serial_frame_parser_xor_test.sv
